### rtl/mtg_pkg.sv
package mtg_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int IDX_W         = $clog2(STATE_WORDS);
	localparam int POS_W         = $clog2(STATE_WORDS + 2);

	localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(STATE_WORDS - 1);
	localparam logic [POS_W-1:0] POS_USED_UP  = POS_W'(STATE_WORDS);
	localparam logic [POS_W-1:0] NEVER_SEEDED = POS_W'(STATE_WORDS + 1);

	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc60000;
	localparam logic [31:0] UPPER_MASK   = 32'h80000000;
	localparam logic [31:0] LOWER_MASK   = 32'h7fffffff;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_FIRST,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_TW_START,
		ST_TW_NXT,
		ST_TW_FAR,
		ST_TW_WR,
		ST_RD,
		ST_OUT
	} mtg_state_t;

	function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt,
			input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_MATRIX;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### rtl/mersenne_twister_generator.sv
// MT19937 generator with 32-bit output. The 624-word state lives in one synchronous RAM
// with a single read and a single write port, and every operation goes through that RAM.
// A draw is accepted, reads its word from the RAM and is tempered into the output
// register once that register is free. A draw that finds all 624 words used up first
// twists the whole state in place, per word reading the next word, reading the word 397
// ahead and writing back. A seed request runs the initialisation recurrence, a 32x32
// multiply and then an add for each word, and gives no result. A draw before
// any seed first seeds with 5489, then twists. New requests are taken only when the block
// is idle; a waiting result does not block a seed request.
module mersenne_twister_generator
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        cmd,
	input  logic [31:0] seed_value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] random_word
);

	logic [31:0] mem [STATE_WORDS];

	mtg_state_t       state_q, state_d;
	logic [POS_W-1:0] pos_q;
	logic             draw_pend_q;
	logic             res_valid_q;
	logic [31:0]      random_word_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      prev_q;
	logic [31:0]      prod_s1;
	logic [31:0]      cur_q;
	logic [31:0]      nxt_q;
	logic [31:0]      rdata_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [31:0]      mem_wdata;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             load_out;
	logic             out_free;
	logic [31:0]      seed_word;
	logic [IDX_W:0]   nxt_sum;
	logic [IDX_W:0]   far_sum;
	logic [IDX_W-1:0] nxt_idx;
	logic [IDX_W-1:0] far_idx;

	assign out_free  = !res_valid_q || !res_stall;
	assign seed_word = prod_s1 + {{(32-IDX_W){1'b0}}, idx_q};
	assign nxt_sum   = {1'b0, idx_q} + (IDX_W+1)'(1);
	assign far_sum   = {1'b0, idx_q} + (IDX_W+1)'(MIDDLE_OFFSET);
	assign nxt_idx   = (nxt_sum >= (IDX_W+1)'(STATE_WORDS)) ?
		IDX_W'(nxt_sum - (IDX_W+1)'(STATE_WORDS)) : nxt_sum[IDX_W-1:0];
	assign far_idx   = (far_sum >= (IDX_W+1)'(STATE_WORDS)) ?
		IDX_W'(far_sum - (IDX_W+1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					priority if (cmd == CMD_SEED || pos_q == NEVER_SEEDED) begin
						state_d = ST_SEED_FIRST;
					end else if (pos_q == POS_USED_UP) begin
						state_d = ST_TW_START;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_SEED_FIRST: state_d = ST_SEED_MUL;
			ST_SEED_MUL:   state_d = ST_SEED_ADD;
			ST_SEED_ADD: begin
				if (idx_q == LAST_IDX) begin
					state_d = draw_pend_q ? ST_TW_START : ST_IDLE;
				end else begin
					state_d = ST_SEED_MUL;
				end
			end
			ST_TW_START: state_d = ST_TW_NXT;
			ST_TW_NXT:   state_d = ST_TW_FAR;
			ST_TW_FAR:   state_d = ST_TW_WR;
			ST_TW_WR:    state_d = (idx_q == LAST_IDX) ? ST_RD : ST_TW_NXT;
			ST_RD:       state_d = ST_OUT;
			ST_OUT:      state_d = out_free ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = seed_word;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_SEED_FIRST: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = prev_q;
			end
			ST_SEED_ADD: mem_we = 1'b1;
			ST_TW_START: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_TW_NXT: begin
				rd_en   = 1'b1;
				rd_addr = nxt_idx;
			end
			ST_TW_FAR: begin
				rd_en   = 1'b1;
				rd_addr = far_idx;
			end
			ST_TW_WR: begin
				mem_we    = 1'b1;
				mem_wdata = twist_word(cur_q, nxt_q, rdata_q);
			end
			ST_RD: begin
				rd_en   = 1'b1;
				rd_addr = pos_q[IDX_W-1:0];
			end
			ST_OUT: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= NEVER_SEEDED;
			draw_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req_valid) begin
				draw_pend_q <= (cmd == CMD_DRAW);
			end
			if (state_q == ST_SEED_ADD && idx_q == LAST_IDX) begin
				pos_q <= POS_USED_UP;
			end
			if (state_q == ST_TW_WR && idx_q == LAST_IDX) begin
				pos_q <= '0;
			end
			if (load_out) begin
				pos_q       <= pos_q + POS_W'(1);
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				prev_q <= (cmd == CMD_SEED) ? seed_value : DEFAULT_SEED;
			end
			ST_SEED_FIRST: idx_q <= IDX_W'(1);
			ST_SEED_MUL:   prod_s1 <= 32'(INIT_MULT * (prev_q ^ (prev_q >> 30)));
			ST_SEED_ADD: begin
				prev_q <= seed_word;
				idx_q  <= idx_q + IDX_W'(1);
			end
			ST_TW_START: idx_q <= '0;
			ST_TW_NXT: begin
				if (idx_q == '0) begin
					cur_q <= rdata_q;
				end
			end
			ST_TW_FAR: nxt_q <= rdata_q;
			ST_TW_WR: begin
				cur_q <= nxt_q;
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_OUT: begin
				if (load_out) begin
					random_word_q <= temper(rdata_q);
				end
			end
			default: ;
		endcase
	end

	assign res_valid   = res_valid_q;
	assign random_word = random_word_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= NEVER_SEEDED)
		else $error("read position out of range");

	a_out_from_live_word: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> pos_q < POS_USED_UP)
		else $error("result taken from a used-up state");

	a_seed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED_ADD && idx_q == LAST_IDX) |=> pos_q == POS_USED_UP)
		else $error("seed did not mark state used up");

	a_twist_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_WR && idx_q == LAST_IDX) |=> (state_q == ST_RD && pos_q == '0))
		else $error("twist did not hand over to a read of word zero");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_RD)
		else $error("state RAM written outside seed or twist");

endmodule

### tb/mersenne_twister_generator_test.sv
`timescale 1ns / 100ps

module mersenne_twister_generator_test;
	import mtg_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        cmd = CMD_DRAW;
	logic [31:0] seed_value = 32'd0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [31:0] random_word;

	logic [31:0]      mt_words [STATE_WORDS];
	logic [POS_W-1:0] mt_pos = NEVER_SEEDED;
	logic [31:0]      expected_words [$];
	logic [31:0]      oldest_word;
	logic             steady = 1'b0;
	int               errors = 0;
	int               draw_count = 0;
	int               seed_count = 0;
	int               twist_count = 0;

	mersenne_twister_generator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.random_word (random_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void seed_words(input logic [31:0] s);
		int i;
		logic [31:0] prev;
		mt_words[0] = s;
		for (i = 1; i < STATE_WORDS; i++) begin
			prev = mt_words[i-1];
			mt_words[i] = INIT_MULT * (prev ^ {30'd0, prev[31:30]}) + 32'(i);
		end
		mt_pos = POS_USED_UP;
	endfunction

	function automatic void twist_all_words();
		int k;
		logic [31:0] y;
		logic [31:0] v;
		for (k = 0; k < STATE_WORDS; k++) begin
			y = {mt_words[k][31], mt_words[(k + 1) % STATE_WORDS][30:0]};
			v = mt_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ {1'b0, y[31:1]};
			if (y[0]) begin
				v = v ^ TWIST_MATRIX;
			end
			mt_words[k] = v;
		end
		mt_pos = '0;
	endfunction

	function automatic logic [31:0] temper_word(input logic [31:0] x);
		logic [31:0] t;
		t = x ^ {11'd0, x[31:11]};
		t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
		t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
		t = t ^ {18'd0, t[31:18]};
		return t;
	endfunction

	function automatic void predict_request(input logic c, input logic [31:0] s);
		if (c == CMD_SEED) begin
			seed_words(s);
			seed_count++;
		end else begin
			if (mt_pos >= POS_USED_UP) begin
				if (mt_pos == NEVER_SEEDED) begin
					seed_words(DEFAULT_SEED);
				end
				twist_all_words();
				twist_count++;
			end
			expected_words.push_back(temper_word(mt_words[mt_pos]));
			mt_pos = mt_pos + 1'b1;
			draw_count++;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(input logic c, input logic [31:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		seed_value <= s;
		do begin
			@(posedge clk);
		end while (req_stall);
		predict_request(c, s);
		@(negedge clk);
	endtask

	task automatic wait_for_words();
		req_valid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic test_unseeded_draw();
		repeat (3) send_request(CMD_DRAW, $urandom());
	endtask

	task automatic test_seed_extremes();
		send_request(CMD_SEED, 32'h0000_0000);
		repeat (2) send_request(CMD_DRAW, 32'hffff_ffff);
		send_request(CMD_SEED, 32'hffff_ffff);
		repeat (2) send_request(CMD_DRAW, 32'h0000_0000);
		send_request(CMD_SEED, DEFAULT_SEED);
		send_request(CMD_DRAW, $urandom());
		send_request(CMD_SEED, 32'h8000_0000);
		send_request(CMD_SEED, 32'h0000_0001);
		repeat (2) send_request(CMD_DRAW, $urandom());
		send_request(CMD_SEED, 32'h7fff_ffff);
		send_request(CMD_SEED, 32'haaaa_aaaa);
		send_request(CMD_SEED, 32'h5555_5555);
		repeat (2) send_request(CMD_DRAW, $urandom());
	endtask

	task automatic test_drained_pause();
		repeat (4) send_request(CMD_DRAW, $urandom());
		wait_for_words();
		send_request(CMD_SEED, $urandom());
		repeat (3) send_request(CMD_DRAW, $urandom());
		wait_for_words();
	endtask

	task automatic test_long_run();
		int n;
		send_request(CMD_SEED, $urandom());
		for (n = 0; n < 630; n++) begin
			steady = (n < 200);
			send_request(CMD_DRAW, $urandom());
		end
		steady = 1'b0;
	endtask

	task automatic test_random_mix();
		int sent;
		int run;
		sent = 0;
		while (sent < 130) begin
			if ($urandom_range(0, 7) != 0) begin
				send_request(CMD_SEED, $urandom());
				sent++;
			end else if ($urandom_range(0, 1) != 0) begin
				send_request(CMD_SEED, $urandom());
				send_request(CMD_SEED, $urandom());
				sent += 2;
			end
			run = $urandom_range(0, 12);
			repeat (run) send_request(CMD_DRAW, $urandom());
			sent += run;
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (steady || $urandom_range(0, 99) < 65) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b1;
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(10, 40)) @(negedge clk);
				end else begin
					repeat ($urandom_range(0, 3)) @(negedge clk);
				end
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected random_word, expected none, actual %h",
					$time, random_word);
				errors++;
			end else begin
				oldest_word = expected_words.pop_front();
				if (random_word !== oldest_word) begin
					$display("%0t: random_word mismatch, expected %h, actual %h",
						$time, oldest_word, random_word);
					errors++;
				end
			end
		end
	end

	initial begin
		#(100_000_000);
		$display("mersenne_twister_generator test failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_unseeded_draw();
		test_seed_extremes();
		test_drained_pause();
		test_long_run();
		test_random_mix();
		wait_for_words();
		repeat (1300) @(posedge clk);
		if (expected_words.size() != 0) begin
			$display("%0t: %0d random_word results never arrived", $time,
				expected_words.size());
			errors++;
		end
		$display("Covered %0d draws and %0d seeds, with %0d full state twists.",
			draw_count, seed_count, twist_count);
		$display("Included an unseeded draw, extreme seeds, back-to-back seeds and a drained pause.");
		if (errors == 0) begin
			$display("mersenne_twister_generator test passed");
		end else begin
			$display("mersenne_twister_generator test failed");
		end
		$finish;
	end

endmodule

### mersenne_twister_generator.f
rtl/mtg_pkg.sv
rtl/mersenne_twister_generator.sv
tb/mersenne_twister_generator_test.sv
